### hdl/smt_pkg.sv
package smt_pkg;

	typedef logic [7:0]  char_t;
	typedef logic [4:0]  tok_t;
	typedef logic [2:0]  err_t;
	typedef logic [1:0]  mode_t;
	typedef logic [15:0] field_t;

	// lexer modes
	localparam mode_t MODE_CMD  = 2'd0;
	localparam mode_t MODE_EXPR = 2'd1;
	localparam mode_t MODE_XCMD = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_COMMENT,
		PH_AT,
		PH_STRING,
		PH_VAR,
		PH_NUMBER,
		PH_IDENT,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP,
		OP_POP_XCMD
	} stack_op_t;

	// token types
	localparam tok_t TK_LBRACK = 5'd0;
	localparam tok_t TK_RBRACK = 5'd1;
	localparam tok_t TK_LPAREN = 5'd2;
	localparam tok_t TK_RPAREN = 5'd3;
	localparam tok_t TK_LBRACE = 5'd4;
	localparam tok_t TK_RBRACE = 5'd5;
	localparam tok_t TK_PIPE   = 5'd6;
	localparam tok_t TK_AT     = 5'd7;
	localparam tok_t TK_SEMI   = 5'd8;
	localparam tok_t TK_QUEST  = 5'd9;
	localparam tok_t TK_BANG   = 5'd10;
	localparam tok_t TK_AMP    = 5'd11;
	localparam tok_t TK_CARET  = 5'd12;
	localparam tok_t TK_GT     = 5'd13;
	localparam tok_t TK_LT     = 5'd14;
	localparam tok_t TK_PLUS   = 5'd15;
	localparam tok_t TK_MINUS  = 5'd16;
	localparam tok_t TK_STAR   = 5'd17;
	localparam tok_t TK_SLASH  = 5'd18;
	localparam tok_t TK_STRING = 5'd19;
	localparam tok_t TK_VAR    = 5'd20;
	localparam tok_t TK_NUMBER = 5'd21;
	localparam tok_t TK_IDENT  = 5'd22;
	localparam tok_t TK_END    = 5'd23;
	localparam tok_t TK_ERROR  = 5'd0;

	// error codes
	localparam err_t ERR_NONE        = 3'd0;
	localparam err_t ERR_NO_PAREN    = 3'd1;
	localparam err_t ERR_OPEN_STRING = 3'd2;
	localparam err_t ERR_EMPTY_VAR   = 3'd3;
	localparam err_t ERR_BAD_CHAR    = 3'd4;
	localparam err_t ERR_OVERFLOW    = 3'd5;
	localparam err_t ERR_UNDERFLOW   = 3'd6;

	// characters
	localparam char_t CH_LF     = 8'h0A;
	localparam char_t CH_TAB    = 8'h09;
	localparam char_t CH_CR     = 8'h0D;
	localparam char_t CH_SPACE  = 8'h20;
	localparam char_t CH_QUOTE  = 8'h22;
	localparam char_t CH_HASH   = 8'h23;
	localparam char_t CH_DOLLAR = 8'h24;
	localparam char_t CH_AMP    = 8'h26;
	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_STAR   = 8'h2A;
	localparam char_t CH_PLUS   = 8'h2B;
	localparam char_t CH_MINUS  = 8'h2D;
	localparam char_t CH_DOT    = 8'h2E;
	localparam char_t CH_SLASH  = 8'h2F;
	localparam char_t CH_0      = 8'h30;
	localparam char_t CH_9      = 8'h39;
	localparam char_t CH_SEMI   = 8'h3B;
	localparam char_t CH_LT     = 8'h3C;
	localparam char_t CH_GT     = 8'h3E;
	localparam char_t CH_QUEST  = 8'h3F;
	localparam char_t CH_AT     = 8'h40;
	localparam char_t CH_UC_A   = 8'h41;
	localparam char_t CH_UC_Z   = 8'h5A;
	localparam char_t CH_LBRACK = 8'h5B;
	localparam char_t CH_RBRACK = 8'h5D;
	localparam char_t CH_CARET  = 8'h5E;
	localparam char_t CH_UNDER  = 8'h5F;
	localparam char_t CH_LC_A   = 8'h61;
	localparam char_t CH_LC_Z   = 8'h7A;
	localparam char_t CH_LBRACE = 8'h7B;
	localparam char_t CH_PIPE   = 8'h7C;
	localparam char_t CH_RBRACE = 8'h7D;
	localparam char_t CH_BANG   = 8'h21;

	// result queue
	typedef logic [1:0] oq_ptr_t;
	typedef logic [2:0] oq_cnt_t;
	localparam int unsigned OQ_DEPTH = 4;
	localparam oq_cnt_t OQ_LIMIT = 3'd2;  // room for two more results
	localparam oq_cnt_t OQ_FULL  = 3'd4;

	typedef struct packed {
		tok_t   tok;
		field_t start;
		field_t length;
		field_t line;
		err_t   err;
		logic   last;
	} result_t;

	typedef struct packed {
		logic      hit;
		tok_t      tok;
		stack_op_t op;
		mode_t     mode;
	} punct_t;

	function automatic logic is_space(char_t c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(char_t c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_word(char_t c);
		return is_digit(c) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
			((c >= CH_LC_A) && (c <= CH_LC_Z)) || (c == CH_UNDER);
	endfunction

	// punctuation decode: token, stack action and pushed mode
	function automatic punct_t punct_info(char_t c);
		punct_t p;
		p = '{hit: 1'b1, tok: TK_PIPE, op: OP_NONE, mode: MODE_CMD};
		unique case (c)
			CH_LBRACK: begin p.tok = TK_LBRACK; p.op = OP_PUSH; p.mode = MODE_CMD; end
			CH_RBRACK: begin p.tok = TK_RBRACK; p.op = OP_POP; end
			CH_LPAREN: begin p.tok = TK_LPAREN; p.op = OP_PUSH; p.mode = MODE_EXPR; end
			CH_RPAREN: begin p.tok = TK_RPAREN; p.op = OP_POP; end
			CH_LBRACE: begin p.tok = TK_LBRACE; p.op = OP_PUSH; p.mode = MODE_CMD; end
			CH_RBRACE: begin p.tok = TK_RBRACE; p.op = OP_POP; end
			CH_PIPE:   p.tok = TK_PIPE;
			CH_AT:     p.tok = TK_AT;
			CH_SEMI:   begin p.tok = TK_SEMI; p.op = OP_POP_XCMD; end
			CH_QUEST:  p.tok = TK_QUEST;
			CH_BANG:   begin p.tok = TK_BANG; p.op = OP_PUSH; p.mode = MODE_XCMD; end
			CH_AMP:    p.tok = TK_AMP;
			CH_CARET:  p.tok = TK_CARET;
			CH_GT:     p.tok = TK_GT;
			CH_LT:     p.tok = TK_LT;
			default:   p.hit = 1'b0;
		endcase
		return p;
	endfunction

endpackage

### hdl/shell_modal_tokenizer_unit.sv
// Streaming shell-language lexer. Text enters one byte per input transaction,
// closed by a transaction with end_of_text set (its byte is ignored). The
// block can take a new transaction in every cycle while in_stall is low; the
// scan state and the mode stack are updated at the accepting edge. Each
// transaction yields zero, one or two result transactions, which wait in a
// four-entry result queue and leave at one per cycle while out_stall is low,
// so the sustained rate is one byte per cycle, and one transaction per result
// when a run of bytes each yields two tokens (a word closed by a punctuation
// byte). in_stall rises when the queue cannot take two more results. The user
// must write base_mode through cfg_en only while the block is idle; the block
// itself does not enforce this. The mode stack sits in a STACK_DEPTH-entry
// memory with registered read; the top entry and the one under it are kept in
// registers, so a push or pop never waits. No clearing pass is needed after
// reset. After an error every byte is dropped until the end transaction,
// which emits the end token and returns all scan state to its reset value.
module shell_modal_tokenizer_unit #(
	parameter int unsigned STACK_DEPTH = 16,
	parameter int unsigned OFFSET_BITS = 16,
	parameter int unsigned LINE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_en,
	input  logic [1:0]  base_mode,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        end_of_text,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_type,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [15:0] token_line,
	output logic [2:0]  error_code,
	output logic        last_result
);

	localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

	typedef logic [OFFSET_BITS-1:0] off_t;
	typedef logic [LINE_BITS-1:0]   line_t;
	typedef logic [LVL_W-1:0]       lvl_t;
	typedef logic [IDX_W-1:0]       idx_t;

	localparam lvl_t LVL_FULL = lvl_t'(STACK_DEPTH);
	localparam lvl_t LVL_TWO  = lvl_t'(2);
	localparam off_t OFF_ONE  = off_t'(1);
	localparam off_t OFF_TWO  = off_t'(2);
	localparam line_t LINE_ONE = line_t'(1);

	// ---------------------------------------------------------------
	// State
	// ---------------------------------------------------------------
	smt_pkg::mode_t  base_q;
	smt_pkg::phase_t phase_q;
	lvl_t            level_q;      // modes stacked above the base mode
	off_t            offset_q;     // offset of the next byte
	line_t           line_q;
	off_t            pstart_q;     // start of the open token
	line_t           pline_q;
	logic            point_q;      // number already holds a '.'

	// mode stack: memory plus cached top and the entry below it
	smt_pkg::mode_t  stack_mem [STACK_DEPTH];
	smt_pkg::mode_t  top_q;
	smt_pkg::mode_t  below_q;

	// result queue
	smt_pkg::result_t   oq_mem [smt_pkg::OQ_DEPTH];
	smt_pkg::oq_ptr_t   wr_ptr_q;
	smt_pkg::oq_ptr_t   rd_ptr_q;
	smt_pkg::oq_cnt_t   count_q;

	logic acc;
	logic pop_out;
	smt_pkg::mode_t top_mode;

	assign acc      = in_valid & ~in_stall;
	assign in_stall = count_q > smt_pkg::OQ_LIMIT;
	assign out_valid = count_q != '0;
	assign pop_out  = out_valid & ~out_stall;
	assign top_mode = (level_q == '0) ? base_q : top_q;

	function automatic smt_pkg::result_t mk_tok(smt_pkg::tok_t tok, off_t start, off_t len,
			line_t ln);
		smt_pkg::result_t r;
		r.tok    = tok;
		r.start  = smt_pkg::field_t'(start);
		r.length = smt_pkg::field_t'(len);
		r.line   = smt_pkg::field_t'(ln);
		r.err    = smt_pkg::ERR_NONE;
		r.last   = 1'b0;
		return r;
	endfunction

	function automatic smt_pkg::result_t mk_err(smt_pkg::err_t code, off_t start, line_t ln);
		smt_pkg::result_t r;
		r     = mk_tok(smt_pkg::TK_ERROR, start, '0, ln);
		r.err = code;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Decode of a byte seen between tokens
	// ---------------------------------------------------------------
	smt_pkg::punct_t  id_pi;
	logic             id_v;
	smt_pkg::result_t id_r;
	smt_pkg::phase_t  id_phase;
	logic             id_pend;       // opens a token
	off_t             id_pstart;
	logic             id_point_clr;
	logic             id_line_inc;
	logic             id_push;
	logic             id_pop;
	smt_pkg::mode_t   id_push_mode;

	always_comb begin
		id_pi        = smt_pkg::punct_info(char_byte);
		id_v         = 1'b0;
		id_r         = '0;
		id_phase     = smt_pkg::PH_IDLE;
		id_pend      = 1'b0;
		id_pstart    = offset_q;
		id_point_clr = 1'b0;
		id_line_inc  = 1'b0;
		id_push      = 1'b0;
		id_pop       = 1'b0;
		id_push_mode = id_pi.mode;
		priority if (smt_pkg::is_space(char_byte)) begin
			id_line_inc = char_byte == smt_pkg::CH_LF;
		end else if (char_byte == smt_pkg::CH_HASH) begin
			id_phase = smt_pkg::PH_COMMENT;
		end else if (char_byte == smt_pkg::CH_AT) begin
			id_phase = smt_pkg::PH_AT;
			id_pend  = 1'b1;
		end else if (id_pi.hit) begin
			id_v = 1'b1;
			id_r = mk_tok(id_pi.tok, offset_q, OFF_ONE, line_q);
			unique case (id_pi.op)
				smt_pkg::OP_PUSH: begin
					if (level_q == LVL_FULL) begin
						id_r     = mk_err(smt_pkg::ERR_OVERFLOW, offset_q, line_q);
						id_phase = smt_pkg::PH_ERROR;
					end else begin
						id_push = 1'b1;
					end
				end
				smt_pkg::OP_POP: begin
					if (level_q == '0) begin
						id_r     = mk_err(smt_pkg::ERR_UNDERFLOW, offset_q, line_q);
						id_phase = smt_pkg::PH_ERROR;
					end else begin
						id_pop = 1'b1;
					end
				end
				smt_pkg::OP_POP_XCMD: begin
					// ';' closes an expression-command, if one is on top
					if (top_mode == smt_pkg::MODE_XCMD) begin
						if (level_q == '0) begin
							id_r     = mk_err(smt_pkg::ERR_UNDERFLOW, offset_q, line_q);
							id_phase = smt_pkg::PH_ERROR;
						end else begin
							id_pop = 1'b1;
						end
					end
				end
				smt_pkg::OP_NONE: begin
				end
			endcase
		end else if (char_byte == smt_pkg::CH_QUOTE) begin
			id_phase  = smt_pkg::PH_STRING;
			id_pend   = 1'b1;
			id_pstart = offset_q + OFF_ONE;
		end else if (char_byte == smt_pkg::CH_DOLLAR) begin
			id_phase  = smt_pkg::PH_VAR;
			id_pend   = 1'b1;
			id_pstart = offset_q + OFF_ONE;
		end else if ((top_mode == smt_pkg::MODE_EXPR) || (top_mode == smt_pkg::MODE_XCMD)) begin
			priority if (smt_pkg::is_digit(char_byte)) begin
				id_phase     = smt_pkg::PH_NUMBER;
				id_pend      = 1'b1;
				id_point_clr = 1'b1;
			end else if (char_byte == smt_pkg::CH_PLUS) begin
				id_v = 1'b1;
				id_r = mk_tok(smt_pkg::TK_PLUS, offset_q, OFF_ONE, line_q);
			end else if (char_byte == smt_pkg::CH_MINUS) begin
				id_v = 1'b1;
				id_r = mk_tok(smt_pkg::TK_MINUS, offset_q, OFF_ONE, line_q);
			end else if (char_byte == smt_pkg::CH_STAR) begin
				id_v = 1'b1;
				id_r = mk_tok(smt_pkg::TK_STAR, offset_q, OFF_ONE, line_q);
			end else if (char_byte == smt_pkg::CH_SLASH) begin
				id_v = 1'b1;
				id_r = mk_tok(smt_pkg::TK_SLASH, offset_q, OFF_ONE, line_q);
			end else begin
				id_v     = 1'b1;
				id_r     = mk_err(smt_pkg::ERR_BAD_CHAR, offset_q, line_q);
				id_phase = smt_pkg::PH_ERROR;
			end
		end else if (top_mode == smt_pkg::MODE_CMD) begin
			id_phase = smt_pkg::PH_IDENT;
			id_pend  = 1'b1;
		end else begin
			// unhandled base mode
			id_v     = 1'b1;
			id_r     = mk_err(smt_pkg::ERR_BAD_CHAR, offset_q, line_q);
			id_phase = smt_pkg::PH_ERROR;
		end
	end

	// ---------------------------------------------------------------
	// Scan step: closes the open token, then decodes the byte if needed
	// ---------------------------------------------------------------
	logic             fin_v;      // token or error from the open construct
	smt_pkg::result_t fin_r;
	logic             sec_v;      // result of the byte itself / end token
	smt_pkg::result_t sec_r;
	logic             run_idle;
	smt_pkg::phase_t  phase_d;
	off_t             offset_d;
	line_t            line_d;
	off_t             pstart_d;
	line_t            pline_d;
	logic             point_d;
	logic             push_en;
	logic             pop_en;
	smt_pkg::mode_t   push_mode;
	off_t             plen;
	logic             clear_all;

	assign plen = offset_q - pstart_q;

	always_comb begin
		fin_v     = 1'b0;
		fin_r     = '0;
		sec_v     = 1'b0;
		sec_r     = '0;
		run_idle  = 1'b0;
		phase_d   = phase_q;
		offset_d  = offset_q + OFF_ONE;
		line_d    = line_q;
		pstart_d  = pstart_q;
		pline_d   = pline_q;
		point_d   = point_q;
		push_en   = 1'b0;
		pop_en    = 1'b0;
		push_mode = smt_pkg::MODE_CMD;
		clear_all = 1'b0;
		if (end_of_text) begin
			// flush whatever is open, then the end token
			unique case (phase_q)
				smt_pkg::PH_AT: begin
					fin_v = 1'b1;
					fin_r = mk_err(smt_pkg::ERR_NO_PAREN, pstart_q, pline_q);
				end
				smt_pkg::PH_STRING: begin
					fin_v = 1'b1;
					fin_r = mk_err(smt_pkg::ERR_OPEN_STRING, pstart_q - OFF_ONE, pline_q);
				end
				smt_pkg::PH_VAR: begin
					fin_v = 1'b1;
					if (plen == '0) begin
						fin_r = mk_err(smt_pkg::ERR_EMPTY_VAR, pstart_q - OFF_ONE, pline_q);
					end else begin
						fin_r = mk_tok(smt_pkg::TK_VAR, pstart_q, plen, pline_q);
					end
				end
				smt_pkg::PH_NUMBER: begin
					fin_v = 1'b1;
					fin_r = mk_tok(smt_pkg::TK_NUMBER, pstart_q, plen, pline_q);
				end
				smt_pkg::PH_IDENT: begin
					fin_v = 1'b1;
					fin_r = mk_tok(smt_pkg::TK_IDENT, pstart_q, plen, pline_q);
				end
				smt_pkg::PH_IDLE, smt_pkg::PH_COMMENT, smt_pkg::PH_ERROR: begin
				end
			endcase
			sec_v     = 1'b1;
			sec_r     = mk_tok(smt_pkg::TK_END, offset_q, '0, line_q);
			clear_all = 1'b1;
			phase_d   = smt_pkg::PH_IDLE;
			offset_d  = '0;
			line_d    = '0;
			pstart_d  = '0;
			pline_d   = '0;
			point_d   = 1'b0;
		end else begin
			unique case (phase_q)
				smt_pkg::PH_IDLE: run_idle = 1'b1;
				smt_pkg::PH_COMMENT: begin
					if (char_byte == smt_pkg::CH_LF) begin
						line_d  = line_q + LINE_ONE;
						phase_d = smt_pkg::PH_IDLE;
					end
				end
				smt_pkg::PH_AT: begin
					fin_v = 1'b1;
					if (char_byte != smt_pkg::CH_LPAREN) begin
						fin_r   = mk_err(smt_pkg::ERR_NO_PAREN, pstart_q, pline_q);
						phase_d = smt_pkg::PH_ERROR;
					end else if (level_q == LVL_FULL) begin
						fin_r   = mk_err(smt_pkg::ERR_OVERFLOW, pstart_q, pline_q);
						phase_d = smt_pkg::PH_ERROR;
					end else begin
						fin_r     = mk_tok(smt_pkg::TK_AT, pstart_q, OFF_TWO, pline_q);
						phase_d   = smt_pkg::PH_IDLE;
						push_en   = 1'b1;
						push_mode = smt_pkg::MODE_CMD;
					end
				end
				smt_pkg::PH_STRING: begin
					if (char_byte == smt_pkg::CH_QUOTE) begin
						fin_v   = 1'b1;
						fin_r   = mk_tok(smt_pkg::TK_STRING, pstart_q, plen, pline_q);
						phase_d = smt_pkg::PH_IDLE;
					end
				end
				smt_pkg::PH_VAR: begin
					if (!smt_pkg::is_word(char_byte)) begin
						fin_v    = 1'b1;
						fin_r    = mk_tok(smt_pkg::TK_VAR, pstart_q, plen, pline_q);
						run_idle = 1'b1;
					end
				end
				smt_pkg::PH_NUMBER: begin
					if (smt_pkg::is_digit(char_byte)) begin
						point_d = point_q;
					end else if ((char_byte == smt_pkg::CH_DOT) && !point_q) begin
						point_d = 1'b1;
					end else begin
						fin_v    = 1'b1;
						fin_r    = mk_tok(smt_pkg::TK_NUMBER, pstart_q, plen, pline_q);
						run_idle = 1'b1;
					end
				end
				smt_pkg::PH_IDENT: begin
					if (smt_pkg::is_space(char_byte) || id_pi.hit) begin
						fin_v    = 1'b1;
						fin_r    = mk_tok(smt_pkg::TK_IDENT, pstart_q, plen, pline_q);
						run_idle = 1'b1;
					end
				end
				smt_pkg::PH_ERROR: begin
				end
			endcase
			if (run_idle) begin
				sec_v   = id_v;
				sec_r   = id_r;
				phase_d = id_phase;
				if (id_pend) begin
					pstart_d = id_pstart;
					pline_d  = line_q;
				end
				if (id_point_clr) begin
					point_d = 1'b0;
				end
				if (id_line_inc) begin
					line_d = line_q + LINE_ONE;
				end
				push_en   = id_push;
				pop_en    = id_pop;
				push_mode = id_push_mode;
			end
		end
	end

	// ---------------------------------------------------------------
	// Mode stack
	// ---------------------------------------------------------------
	lvl_t lvl_next;
	idx_t rd_idx;

	always_comb begin
		lvl_next = level_q;
		if (acc) begin
			priority if (clear_all) begin
				lvl_next = '0;
			end else if (push_en) begin
				lvl_next = level_q + lvl_t'(1);
			end else if (pop_en) begin
				lvl_next = level_q - lvl_t'(1);
			end
		end
	end

	// prefetch the entry under the next top
	assign rd_idx = (lvl_next >= LVL_TWO) ? idx_t'(lvl_next - LVL_TWO) : '0;

	always_ff @(posedge clk) begin
		if (acc && push_en) begin
			stack_mem[level_q[IDX_W-1:0]] <= push_mode;
		end
		below_q <= stack_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (acc && push_en) begin
			top_q <= push_mode;
		end else if (acc && pop_en) begin
			top_q <= below_q;
		end
	end

	// ---------------------------------------------------------------
	// Scan state registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= smt_pkg::MODE_CMD;
			phase_q  <= smt_pkg::PH_IDLE;
			level_q  <= '0;
			offset_q <= '0;
			line_q   <= '0;
			pstart_q <= '0;
			pline_q  <= '0;
			point_q  <= 1'b0;
		end else begin
			if (cfg_en) begin
				base_q <= base_mode;
			end
			level_q <= lvl_next;
			if (acc) begin
				phase_q  <= phase_d;
				offset_q <= offset_d;
				line_q   <= line_d;
				pstart_q <= pstart_d;
				pline_q  <= pline_d;
				point_q  <= point_d;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result queue: up to two writes per transaction, one read
	// ---------------------------------------------------------------
	logic             res0_v;
	logic             res1_v;
	smt_pkg::result_t res0;
	smt_pkg::result_t res1;
	smt_pkg::oq_cnt_t n_push;
	smt_pkg::result_t oq_head;

	always_comb begin
		res0_v    = acc & (fin_v | sec_v);
		res1_v    = acc & fin_v & sec_v;
		res0      = fin_v ? fin_r : sec_r;
		res0.last = !(fin_v && sec_v);
		res1      = sec_r;
		res1.last = 1'b1;
		n_push    = smt_pkg::oq_cnt_t'(res0_v) + smt_pkg::oq_cnt_t'(res1_v);
	end

	always_ff @(posedge clk) begin
		if (res0_v) begin
			oq_mem[wr_ptr_q] <= res0;
		end
		if (res1_v) begin
			oq_mem[wr_ptr_q + smt_pkg::oq_ptr_t'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + smt_pkg::oq_ptr_t'(n_push);
			if (pop_out) begin
				rd_ptr_q <= rd_ptr_q + smt_pkg::oq_ptr_t'(1);
			end
			count_q <= count_q + n_push - smt_pkg::oq_cnt_t'(pop_out);
		end
	end

	assign oq_head      = oq_mem[rd_ptr_q];
	assign token_type   = oq_head.tok;
	assign token_start  = oq_head.start;
	assign token_length = oq_head.length;
	assign token_line   = oq_head.line;
	assign error_code   = oq_head.err;
	assign last_result  = oq_head.last;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= smt_pkg::OQ_FULL)
		else $error("result queue overrun");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_FULL)
		else $error("mode stack level beyond depth");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && end_of_text |=> level_q == '0 && phase_q == smt_pkg::PH_IDLE && offset_q == '0)
		else $error("end transaction did not clear scan state");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc && end_of_text |=> count_q != '0)
		else $error("end transaction produced no result");

endmodule

### dv/shell_modal_tokenizer_unit_tb.sv
`timescale 1ns / 100ps

module shell_modal_tokenizer_unit_tb;

	localparam int unsigned STACK_SLOTS   = 16;
	localparam int unsigned SETTLE_CYCLES = 16;    // result queue plus a margin
	localparam int unsigned LONG_HOLD     = 200;   // receiver hold-off, in cycles
	localparam int unsigned RANDOM_BYTES  = 1450;

	// Scoreboard: a lexer of its own that turns each accepted input transaction
	// into the tokens it must produce, and a queue of the tokens still owed.
	class lexer_scoreboard;
		smt_pkg::result_t tokens_due[$];
		smt_pkg::result_t batch[$];
		smt_pkg::mode_t   base;
		smt_pkg::mode_t   modes[STACK_SLOTS];
		int unsigned      level;
		smt_pkg::phase_t  phase;
		smt_pkg::field_t  offset;
		smt_pkg::field_t  line_no;
		smt_pkg::field_t  tok_start;
		smt_pkg::field_t  tok_line;
		bit               point;
		int unsigned      mismatches;

		function new();
			base = smt_pkg::MODE_CMD;
			mismatches = 0;
			foreach (modes[i]) modes[i] = smt_pkg::MODE_CMD;
			clear_scan();
		endfunction

		function void clear_scan();
			phase = smt_pkg::PH_IDLE;
			level = 0;
			offset = '0;
			line_no = '0;
			tok_start = '0;
			tok_line = '0;
			point = 1'b0;
		endfunction

		function void set_base(smt_pkg::mode_t m);
			base = m;
		endfunction

		function int unsigned pending();
			return tokens_due.size();
		endfunction

		function bit dropping();
			return phase == smt_pkg::PH_ERROR;
		endfunction

		function int unsigned depth();
			return level;
		endfunction

		function smt_pkg::mode_t mode_now();
			return (level == 0) ? base : modes[level - 1];
		endfunction

		function bit blank(smt_pkg::char_t c);
			return c inside {[smt_pkg::CH_TAB:smt_pkg::CH_CR], smt_pkg::CH_SPACE};
		endfunction

		function bit numeral(smt_pkg::char_t c);
			return c inside {[smt_pkg::CH_0:smt_pkg::CH_9]};
		endfunction

		function bit word_byte(smt_pkg::char_t c);
			return c inside {[smt_pkg::CH_0:smt_pkg::CH_9],
				[smt_pkg::CH_UC_A:smt_pkg::CH_UC_Z],
				[smt_pkg::CH_LC_A:smt_pkg::CH_LC_Z], smt_pkg::CH_UNDER};
		endfunction

		function bit ends_word(smt_pkg::char_t c);
			return blank(c) || c inside {smt_pkg::CH_LBRACK, smt_pkg::CH_RBRACK,
				smt_pkg::CH_LPAREN, smt_pkg::CH_RPAREN, smt_pkg::CH_LBRACE,
				smt_pkg::CH_RBRACE, smt_pkg::CH_PIPE, smt_pkg::CH_AT, smt_pkg::CH_SEMI,
				smt_pkg::CH_QUEST, smt_pkg::CH_AMP, smt_pkg::CH_BANG, smt_pkg::CH_CARET,
				smt_pkg::CH_GT, smt_pkg::CH_LT};
		endfunction

		function smt_pkg::field_t span_len();
			return offset - tok_start;
		endfunction

		function void emit(smt_pkg::tok_t t, smt_pkg::field_t s, smt_pkg::field_t n,
				smt_pkg::field_t ln, smt_pkg::err_t e);
			smt_pkg::result_t r;
			r.tok = t;
			r.start = s;
			r.length = n;
			r.line = ln;
			r.err = e;
			r.last = 1'b0;
			batch.push_back(r);
		endfunction

		function void abort(smt_pkg::err_t e, smt_pkg::field_t s, smt_pkg::field_t ln);
			emit(smt_pkg::TK_ERROR, s, '0, ln, e);
			phase = smt_pkg::PH_ERROR;
		endfunction

		function void open_token(smt_pkg::phase_t p, smt_pkg::field_t s);
			phase = p;
			tok_start = s;
			tok_line = line_no;
		endfunction

		function void idle_byte(smt_pkg::char_t c);
			smt_pkg::field_t    pos;
			smt_pkg::tok_t      t;
			smt_pkg::stack_op_t op;
			smt_pkg::mode_t     pushed;
			bit                 hit;
			pos = offset;
			t = smt_pkg::TK_PIPE;
			op = smt_pkg::OP_NONE;
			pushed = smt_pkg::MODE_CMD;
			hit = 1'b1;
			if (blank(c)) begin
				if (c == smt_pkg::CH_LF) line_no++;
				return;
			end
			if (c == smt_pkg::CH_HASH) begin
				phase = smt_pkg::PH_COMMENT;
				return;
			end
			if (c == smt_pkg::CH_AT) begin
				open_token(smt_pkg::PH_AT, pos);
				return;
			end
			case (c)
				smt_pkg::CH_LBRACK: begin
					t = smt_pkg::TK_LBRACK;
					op = smt_pkg::OP_PUSH;
					pushed = smt_pkg::MODE_CMD;
				end
				smt_pkg::CH_RBRACK: begin
					t = smt_pkg::TK_RBRACK;
					op = smt_pkg::OP_POP;
				end
				smt_pkg::CH_LPAREN: begin
					t = smt_pkg::TK_LPAREN;
					op = smt_pkg::OP_PUSH;
					pushed = smt_pkg::MODE_EXPR;
				end
				smt_pkg::CH_RPAREN: begin
					t = smt_pkg::TK_RPAREN;
					op = smt_pkg::OP_POP;
				end
				smt_pkg::CH_LBRACE: begin
					t = smt_pkg::TK_LBRACE;
					op = smt_pkg::OP_PUSH;
					pushed = smt_pkg::MODE_CMD;
				end
				smt_pkg::CH_RBRACE: begin
					t = smt_pkg::TK_RBRACE;
					op = smt_pkg::OP_POP;
				end
				smt_pkg::CH_PIPE:   t = smt_pkg::TK_PIPE;
				smt_pkg::CH_SEMI: begin
					t = smt_pkg::TK_SEMI;
					op = smt_pkg::OP_POP_XCMD;
				end
				smt_pkg::CH_QUEST:  t = smt_pkg::TK_QUEST;
				smt_pkg::CH_BANG: begin
					t = smt_pkg::TK_BANG;
					op = smt_pkg::OP_PUSH;
					pushed = smt_pkg::MODE_XCMD;
				end
				smt_pkg::CH_AMP:    t = smt_pkg::TK_AMP;
				smt_pkg::CH_CARET:  t = smt_pkg::TK_CARET;
				smt_pkg::CH_GT:     t = smt_pkg::TK_GT;
				smt_pkg::CH_LT:     t = smt_pkg::TK_LT;
				default:            hit = 1'b0;
			endcase
			if (hit) begin
				case (op)
					smt_pkg::OP_PUSH: begin
						if (level >= STACK_SLOTS) begin
							abort(smt_pkg::ERR_OVERFLOW, pos, line_no);
							return;
						end
						modes[level] = pushed;
						level++;
					end
					smt_pkg::OP_POP: begin
						if (level == 0) begin
							abort(smt_pkg::ERR_UNDERFLOW, pos, line_no);
							return;
						end
						level--;
					end
					smt_pkg::OP_POP_XCMD: begin
						if (mode_now() == smt_pkg::MODE_XCMD) begin
							if (level == 0) begin
								abort(smt_pkg::ERR_UNDERFLOW, pos, line_no);
								return;
							end
							level--;
						end
					end
					default: ;
				endcase
				emit(t, pos, 1, line_no, smt_pkg::ERR_NONE);
				return;
			end
			if (c == smt_pkg::CH_QUOTE) begin
				open_token(smt_pkg::PH_STRING, pos + 1);
				return;
			end
			if (c == smt_pkg::CH_DOLLAR) begin
				open_token(smt_pkg::PH_VAR, pos + 1);
				return;
			end
			case (mode_now())
				smt_pkg::MODE_EXPR, smt_pkg::MODE_XCMD: begin
					if (numeral(c)) begin
						open_token(smt_pkg::PH_NUMBER, pos);
						point = 1'b0;
					end else if (c == smt_pkg::CH_PLUS)
						emit(smt_pkg::TK_PLUS, pos, 1, line_no, smt_pkg::ERR_NONE);
					else if (c == smt_pkg::CH_MINUS)
						emit(smt_pkg::TK_MINUS, pos, 1, line_no, smt_pkg::ERR_NONE);
					else if (c == smt_pkg::CH_STAR)
						emit(smt_pkg::TK_STAR, pos, 1, line_no, smt_pkg::ERR_NONE);
					else if (c == smt_pkg::CH_SLASH)
						emit(smt_pkg::TK_SLASH, pos, 1, line_no, smt_pkg::ERR_NONE);
					else abort(smt_pkg::ERR_BAD_CHAR, pos, line_no);
				end
				smt_pkg::MODE_CMD: open_token(smt_pkg::PH_IDENT, pos);
				default:  abort(smt_pkg::ERR_BAD_CHAR, pos, line_no);
			endcase
		endfunction

		// one accepted input transaction
		function void take_byte(smt_pkg::char_t c, logic eot);
			smt_pkg::field_t quote_pos;
			batch.delete();
			if (eot) begin
				quote_pos = tok_start - 1;
				case (phase)
					smt_pkg::PH_AT:
						abort(smt_pkg::ERR_NO_PAREN, tok_start, tok_line);
					smt_pkg::PH_STRING:
						abort(smt_pkg::ERR_OPEN_STRING, quote_pos, tok_line);
					smt_pkg::PH_VAR: begin
						if (span_len() == 0)
							abort(smt_pkg::ERR_EMPTY_VAR, quote_pos, tok_line);
						else
							emit(smt_pkg::TK_VAR, tok_start, span_len(), tok_line,
								smt_pkg::ERR_NONE);
					end
					smt_pkg::PH_NUMBER:
						emit(smt_pkg::TK_NUMBER, tok_start, span_len(), tok_line,
							smt_pkg::ERR_NONE);
					smt_pkg::PH_IDENT:
						emit(smt_pkg::TK_IDENT, tok_start, span_len(), tok_line,
							smt_pkg::ERR_NONE);
					default: ;
				endcase
				emit(smt_pkg::TK_END, offset, '0, line_no, smt_pkg::ERR_NONE);
				clear_scan();
			end else begin
				case (phase)
					smt_pkg::PH_IDLE: idle_byte(c);
					smt_pkg::PH_COMMENT: begin
						if (c == smt_pkg::CH_LF) begin
							line_no++;
							phase = smt_pkg::PH_IDLE;
						end
					end
					smt_pkg::PH_AT: begin
						if (c != smt_pkg::CH_LPAREN)
							abort(smt_pkg::ERR_NO_PAREN, tok_start, tok_line);
						else if (level >= STACK_SLOTS)
							abort(smt_pkg::ERR_OVERFLOW, tok_start, tok_line);
						else begin
							modes[level] = smt_pkg::MODE_CMD;
							level++;
							phase = smt_pkg::PH_IDLE;
							emit(smt_pkg::TK_AT, tok_start, 2, tok_line, smt_pkg::ERR_NONE);
						end
					end
					smt_pkg::PH_STRING: begin
						if (c == smt_pkg::CH_QUOTE) begin
							phase = smt_pkg::PH_IDLE;
							emit(smt_pkg::TK_STRING, tok_start, span_len(), tok_line,
								smt_pkg::ERR_NONE);
						end
					end
					smt_pkg::PH_VAR: begin
						if (!word_byte(c)) begin
							phase = smt_pkg::PH_IDLE;
							emit(smt_pkg::TK_VAR, tok_start, span_len(), tok_line,
								smt_pkg::ERR_NONE);
							idle_byte(c);
						end
					end
					smt_pkg::PH_NUMBER: begin
						if (!numeral(c)) begin
							if (c == smt_pkg::CH_DOT && !point) point = 1'b1;
							else begin
								phase = smt_pkg::PH_IDLE;
								emit(smt_pkg::TK_NUMBER, tok_start, span_len(), tok_line,
									smt_pkg::ERR_NONE);
								idle_byte(c);
							end
						end
					end
					smt_pkg::PH_IDENT: begin
						if (ends_word(c)) begin
							phase = smt_pkg::PH_IDLE;
							emit(smt_pkg::TK_IDENT, tok_start, span_len(), tok_line,
								smt_pkg::ERR_NONE);
							idle_byte(c);
						end
					end
					default: ;
				endcase
				offset++;
			end
			if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i]) tokens_due.push_back(batch[i]);
		endfunction

		function string show(smt_pkg::result_t r);
			return $sformatf("tok=%0d start=%0d len=%0d line=%0d err=%0d last=%0d",
				r.tok, r.start, r.length, r.line, r.err, r.last);
		endfunction

		// one accepted result transaction
		function void check_token(smt_pkg::result_t got);
			smt_pkg::result_t want;
			if (tokens_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: token with nothing owed: %s", $time, show(got));
				return;
			end
			want = tokens_due.pop_front();
			if (got.tok !== want.tok || got.start !== want.start ||
					got.length !== want.length || got.line !== want.line ||
					got.err !== want.err || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: token mismatch: expected %s, got %s",
						$time, show(want), show(got));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_en;
	logic [1:0]  base_mode;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_byte;
	logic        end_of_text;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  token_type;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [15:0] token_line;
	logic [2:0]  error_code;
	logic        last_result;

	lexer_scoreboard ledger = new();

	int unsigned burst_left   = 0;     // transactions left in the sender's burst
	int unsigned live_bytes   = 0;     // transactions the lexer did not drop
	bit          hold_request = 1'b0;  // sender asks the receiver for a long hold-off

	shell_modal_tokenizer_unit #(
		.STACK_DEPTH(STACK_SLOTS),
		.OFFSET_BITS(16),
		.LINE_BITS(16)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_en(cfg_en),
		.base_mode(base_mode),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_byte(char_byte),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_type(token_type),
		.token_start(token_start),
		.token_length(token_length),
		.token_line(token_line),
		.error_code(error_code),
		.last_result(last_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: values are read just after the edge, so they are the ones
	// the block saw at that edge.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			ledger.check_token(smt_pkg::result_t'({token_type, token_start, token_length,
				token_line, error_code, last_result}));
	end

	// Receiver: stall style changes from one random-length span to the next - none,
	// sparse random, periodic, heavy. A hold request from the sender freezes the
	// result channel for the LONG_HOLD hold-off so the queue backs up into in_stall.
	initial begin : receiver
		int unsigned style;
		int unsigned span;
		int unsigned tick;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			style = $urandom_range(0, 4);
			span = $urandom_range(16, 160);
			for (tick = 0; tick < span; tick++) begin
				@(posedge clk);
				if (hold_request) begin
					hold_request = 1'b0;
					out_stall <= 1'b1;
					repeat (LONG_HOLD) @(posedge clk);
				end
				case (style)
					1:       out_stall <= ($urandom_range(0, 99) < 30);
					2:       out_stall <= ((tick % 5) == 2);
					3:       out_stall <= ($urandom_range(0, 99) < 75);
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	// One input transaction. Bursts of random length with random gaps between
	// them; valid stays up from one transaction to the next inside a burst.
	task automatic send_item(smt_pkg::char_t c, logic eot);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		char_byte <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		if (eot || !ledger.dropping()) begin
			live_bytes++;
			if (live_bytes == 400 || live_bytes == 1100) hold_request = 1'b1;
		end
		ledger.take_byte(c, eot);
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_item(smt_pkg::char_t'(s[i]), 1'b0);
	endtask

	// Sender stops and waits until every owed token is out, then lets the
	// result queue settle; bytes that end nothing give no token to wait for.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// base_mode is only touched while the block is idle
	task automatic write_base(smt_pkg::mode_t m);
		cfg_en <= 1'b1;
		base_mode <= m;
		@(posedge clk);
		cfg_en <= 1'b0;
		ledger.set_base(m);
	endtask

	function automatic smt_pkg::char_t word_char();
		case ($urandom_range(0, 3))
			0:       return smt_pkg::char_t'($urandom_range(smt_pkg::CH_0, smt_pkg::CH_9));
			1:       return smt_pkg::char_t'($urandom_range(smt_pkg::CH_UC_A,
				smt_pkg::CH_UC_Z));
			2:       return smt_pkg::char_t'($urandom_range(smt_pkg::CH_LC_A,
				smt_pkg::CH_LC_Z));
			default: return smt_pkg::CH_UNDER;
		endcase
	endfunction

	function automatic smt_pkg::char_t printable();
		return smt_pkg::char_t'($urandom_range(smt_pkg::CH_SPACE, 8'h7E));
	endfunction

	task automatic send_blank();
		if ($urandom_range(0, 1) == 0) send_item(smt_pkg::CH_SPACE, 1'b0);
		else send_item(smt_pkg::char_t'($urandom_range(smt_pkg::CH_TAB, smt_pkg::CH_CR)),
			1'b0);
	endtask

	task automatic send_opener();
		case ($urandom_range(0, 4))
			0: send_item(smt_pkg::CH_LBRACK, 1'b0);
			1: send_item(smt_pkg::CH_LPAREN, 1'b0);
			2: send_item(smt_pkg::CH_LBRACE, 1'b0);
			3: send_item(smt_pkg::CH_BANG, 1'b0);
			default: begin
				send_item(smt_pkg::CH_AT, 1'b0);
				// mostly a proper @( pair, sometimes a broken one
				if ($urandom_range(0, 9) != 0) send_item(smt_pkg::CH_LPAREN, 1'b0);
				else send_item(word_char(), 1'b0);
			end
		endcase
	endtask

	task automatic send_closer();
		// popping an empty stack is kept rare so most texts run deep
		if (ledger.depth() == 0 && $urandom_range(0, 7) != 0) send_blank();
		else if (ledger.mode_now() == smt_pkg::MODE_XCMD && $urandom_range(0, 1) == 0)
			send_item(smt_pkg::CH_SEMI, 1'b0);
		else begin
			case ($urandom_range(0, 3))
				0:       send_item(smt_pkg::CH_RBRACK, 1'b0);
				1:       send_item(smt_pkg::CH_RPAREN, 1'b0);
				2:       send_item(smt_pkg::CH_RBRACE, 1'b0);
				default: send_item(smt_pkg::CH_SEMI, 1'b0);
			endcase
		end
	endtask

	// One lexical piece, picked to suit the current mode most of the time.
	task automatic send_piece();
		int unsigned    pick;
		int unsigned    n;
		int unsigned    i;
		smt_pkg::char_t c;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			send_item(smt_pkg::char_t'($urandom), 1'b0);
		end else if (pick < 6) begin
			// deep nesting, runs the mode stack out now and then
			n = $urandom_range(10, 18);
			for (i = 0; i < n; i++) send_opener();
		end else if (pick < 18) begin
			send_opener();
		end else if (pick < 30) begin
			send_closer();
		end else if (pick < 40) begin
			send_blank();
		end else if (pick < 44) begin
			send_item(smt_pkg::CH_HASH, 1'b0);
			n = $urandom_range(0, 5);
			for (i = 0; i < n; i++) send_item(printable(), 1'b0);
			send_item(smt_pkg::CH_LF, 1'b0);
		end else if (pick < 51) begin
			// string, newlines inside, sometimes left open
			send_item(smt_pkg::CH_QUOTE, 1'b0);
			n = $urandom_range(0, 6);
			for (i = 0; i < n; i++) begin
				c = ($urandom_range(0, 7) == 0) ? smt_pkg::CH_LF : printable();
				send_item((c == smt_pkg::CH_QUOTE) ? smt_pkg::CH_SPACE : c, 1'b0);
			end
			if ($urandom_range(0, 9) != 0) send_item(smt_pkg::CH_QUOTE, 1'b0);
		end else if (pick < 58) begin
			send_item(smt_pkg::CH_DOLLAR, 1'b0);
			n = $urandom_range(0, 4);
			for (i = 0; i < n; i++) send_item(word_char(), 1'b0);
		end else if (pick < 66) begin
			case ($urandom_range(0, 5))
				0:       send_item(smt_pkg::CH_PIPE, 1'b0);
				1:       send_item(smt_pkg::CH_QUEST, 1'b0);
				2:       send_item(smt_pkg::CH_AMP, 1'b0);
				3:       send_item(smt_pkg::CH_CARET, 1'b0);
				4:       send_item(smt_pkg::CH_GT, 1'b0);
				default: send_item(smt_pkg::CH_LT, 1'b0);
			endcase
		end else if (ledger.mode_now() == smt_pkg::MODE_CMD) begin
			// identifier: any byte that is not a separator goes
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++)
				send_item(($urandom_range(0, 5) == 0) ? printable() : word_char(), 1'b0);
			if ($urandom_range(0, 2) != 0) send_blank();
		end else begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					send_item(smt_pkg::char_t'($urandom_range(smt_pkg::CH_0,
						smt_pkg::CH_9)), 1'b0);
				if ($urandom_range(0, 1) == 0) begin
					send_item(smt_pkg::CH_DOT, 1'b0);
					n = $urandom_range(0, 3);
					for (i = 0; i < n; i++)
						send_item(smt_pkg::char_t'($urandom_range(smt_pkg::CH_0,
							smt_pkg::CH_9)), 1'b0);
					// a second point closes the number and is a bad byte
					if ($urandom_range(0, 11) == 0) send_item(smt_pkg::CH_DOT, 1'b0);
				end
			end else if (pick < 9) begin
				case ($urandom_range(0, 3))
					0:       send_item(smt_pkg::CH_PLUS, 1'b0);
					1:       send_item(smt_pkg::CH_MINUS, 1'b0);
					2:       send_item(smt_pkg::CH_STAR, 1'b0);
					default: send_item(smt_pkg::CH_SLASH, 1'b0);
				endcase
			end else begin
				send_item(smt_pkg::char_t'($urandom_range(smt_pkg::CH_LC_A,
					smt_pkg::CH_LC_Z)), 1'b0);
			end
			if ($urandom_range(0, 1) == 0) send_blank();
		end
	endtask

	// A text stops early once it hits an error: the rest would be dropped.
	task automatic send_random_text();
		int unsigned pieces;
		int unsigned k;
		pieces = $urandom_range(2, 24);
		for (k = 0; k < pieces && !ledger.dropping(); k++) send_piece();
		send_item(smt_pkg::char_t'($urandom), 1'b1);
	endtask

	initial begin : stimulus
		int unsigned    random_from;
		int unsigned    round;
		int unsigned    texts;
		int unsigned    k;
		smt_pkg::mode_t next_base;
		arst_n = 1'b0;
		cfg_en <= 1'b0;
		base_mode <= smt_pkg::MODE_CMD;
		in_valid <= 1'b0;
		char_byte <= '0;
		end_of_text <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: command mode - identifier of the extreme bytes, every
		// punctuation but {, var, number with a point, comment, newline in a string,
		// the @( pair and the ! / ; pair.
		write_base(smt_pkg::MODE_CMD);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("[$v](1.5*2)#\n\"s\n\"@(|?&^><!;}");
		send_item(8'h00, 1'b1);
		// error cases, each closed by an end transaction
		send_text(")");            // pop of an empty stack
		send_item(8'hFF, 1'b1);
		send_text("@x");           // @ without (
		send_item(8'h00, 1'b1);
		send_text("\"ab");         // string still open at the end
		send_item(8'h00, 1'b1);
		send_text("$");            // bare $ at the end
		send_item(8'h00, 1'b1);
		drain();
		// expression base: three of the operators, then a letter is a bad byte
		write_base(smt_pkg::MODE_EXPR);
		send_text("7-8/9+a");
		send_item(8'h00, 1'b1);

		// Random: rounds of texts, base mode rewritten between rounds while
		// idle; first rounds walk every mode.
		random_from = live_bytes;
		round = 0;
		while (live_bytes - random_from < RANDOM_BYTES) begin
			drain();
			case ((round < 3) ? round : $urandom_range(0, 2))
				0:       next_base = smt_pkg::MODE_CMD;
				1:       next_base = smt_pkg::MODE_EXPR;
				default: next_base = smt_pkg::MODE_XCMD;
			endcase
			write_base(next_base);
			texts = $urandom_range(2, 6);
			for (k = 0; k < texts; k++) send_random_text();
			round++;
		end

		drain();
		if (ledger.mismatches == 0 && ledger.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
hdl/smt_pkg.sv
hdl/shell_modal_tokenizer_unit.sv
dv/shell_modal_tokenizer_unit_tb.sv
